>>> src/omd_pkg.sv
// Shared types, constants and functions of the three-wheel omni drive mixer.
// Holds the heading correction rule, the cosine table builder and the lane
// control types; every other file of the block imports it.
package omd_pkg;

  localparam int COS_FRAC_BITS_DEF = 15;
  localparam int HDG_W      = 9;
  localparam int PWR_W      = 8;
  localparam int ZONE_W     = 4;
  localparam int SPIN_W     = 9;
  localparam int DRV_W      = 10;
  localparam int ANG_W      = 9;
  localparam int SUM_W      = 10;
  localparam int STEP_W     = 3;
  localparam int NUM_WHEELS = 3;
  localparam int QTR_N      = 91;
  localparam int QTR_IDX_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int WHEEL_LEFT  = 0;
  localparam int WHEEL_RIGHT = 1;
  localparam int WHEEL_BACK  = 2;

  localparam logic [PWR_W-1:0] ON_LINE_POWER_RST = 8'd128;
  localparam logic [ANG_W-1:0] LEFT_ANGLE_RST    = 9'd60;
  localparam logic [ANG_W-1:0] RIGHT_ANGLE_RST   = 9'd300;
  localparam logic [ANG_W-1:0] BACK_ANGLE_RST    = 9'd180;

  localparam logic [STEP_W-1:0] STEP_LAST = '1;

  // pi in Q2.30 and the divisors (2n-1)(2n) of the cosine series.
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned SeriesDiv [10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_LINE_POWER = 2'd0,
    CFG_LEFT_ANGLE    = 2'd1,
    CFG_RIGHT_ANGLE   = 2'd2,
    CFG_BACK_ANGLE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_FIELD     = 4'd0,
    ZONE_LEFT      = 4'd1,
    ZONE_RIGHT     = 4'd2,
    ZONE_FRONT     = 4'd3,
    ZONE_FRONT_MID = 4'd4,
    ZONE_BACK      = 4'd5,
    ZONE_CORNER_BL = 4'd6,
    ZONE_CORNER_BR = 4'd7,
    ZONE_CORNER_FL = 4'd8,
    ZONE_CORNER_FR = 4'd9
  } zone_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_LOOKUP,
    ST_MULT,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_DONE
  } omd_state_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic div_load;
    logic div_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic [QTR_IDX_W-1:0] k;
    logic                 neg;
  } cos_fold_t;

  typedef logic [31:0] cos_tab_t [QTR_N];

  // Rounded cos(k degrees) for k in 0..90 with frac fraction bits.
  function automatic longint unsigned quarter_cos(int unsigned k, int unsigned frac);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / SeriesDiv[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return (longint'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

  function automatic cos_tab_t cos_table(int unsigned frac);
    cos_tab_t tab;
    for (int k = 0; k < QTR_N; k++) begin
      tab[k] = 32'(quarter_cos(k, frac));
    end
    return tab;
  endfunction

  // Reduces an angle sum below 1080 to one quadrant and a sign.
  function automatic cos_fold_t cos_fold(logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] d;
    logic [SUM_W-1:0] t;
    cos_fold_t        r;
    if (s >= 10'd720) begin
      d = s - 10'd720;
    end else if (s >= 10'd360) begin
      d = s - 10'd360;
    end else begin
      d = s;
    end
    if (d <= 10'd90) begin
      t     = d;
      r.neg = 1'b0;
    end else if (d <= 10'd180) begin
      t     = 10'd180 - d;
      r.neg = 1'b1;
    end else if (d <= 10'd270) begin
      t     = d - 10'd180;
      r.neg = 1'b1;
    end else begin
      t     = 10'd360 - d;
      r.neg = 1'b0;
    end
    r.k = t[QTR_IDX_W-1:0];
    return r;
  endfunction

  // Bends the heading away from a reported line.
  function automatic logic [HDG_W-1:0] correct_heading(logic [HDG_W-1:0] d,
                                                       logic [ZONE_W-1:0] zone);
    logic [HDG_W-1:0] r;
    r = d;
    case (zone)
      ZONE_LEFT: begin
        if (d >= 9'd270) r = 9'd20;
        else if (d >= 9'd180) r = 9'd160;
      end
      ZONE_RIGHT: begin
        if (d <= 9'd90 || d >= 9'd340) r = 9'd340;
        else if (d <= 9'd200) r = 9'd200;
      end
      ZONE_FRONT: begin
        if (d <= 9'd110) r = 9'd110;
        else if (d >= 9'd250) r = 9'd250;
      end
      ZONE_FRONT_MID: r = 9'd180;
      ZONE_BACK: begin
        if (d inside {[9'd70:9'd179]}) r = 9'd70;
        else if (d inside {[9'd180:9'd290]}) r = 9'd290;
      end
      ZONE_CORNER_BL: begin
        if (d inside {[9'd70:9'd224]}) r = 9'd70;
        else if (d >= 9'd225 || d <= 9'd20) r = 9'd20;
      end
      ZONE_CORNER_BR: begin
        if (d inside {[9'd136:9'd290]}) r = 9'd290;
        else if (d <= 9'd135 || d >= 9'd340) r = 9'd340;
      end
      ZONE_CORNER_FL: begin
        if (d <= 9'd110 || d > 9'd315) r = 9'd110;
        else if (d inside {[9'd180:9'd315]}) r = 9'd160;
      end
      ZONE_CORNER_FR: begin
        if (d >= 9'd250 || d < 9'd45) r = 9'd250;
        else if (d inside {[9'd45:9'd200]}) r = 9'd200;
      end
      default: r = d;
    endcase
    return r;
  endfunction

endpackage

>>> src/omd_channels.sv
// Valid/ready channel interfaces of the omni drive mixer: input items,
// result items and configuration writes. Depends on omd_pkg for widths.
interface omd_in_if import omd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [HDG_W-1:0]         heading;
  logic [PWR_W-1:0]         drive_power;
  logic [ZONE_W-1:0]        line_zone;
  logic signed [SPIN_W-1:0] spin;

  modport source (output valid, heading, drive_power, line_zone, spin, input ready);
  modport sink (input valid, heading, drive_power, line_zone, spin, output ready);
endinterface

interface omd_out_if import omd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] left_drive;
  logic signed [DRV_W-1:0] right_drive;
  logic signed [DRV_W-1:0] back_drive;
  logic [HDG_W-1:0]        applied_heading;

  modport source (output valid, left_drive, right_drive, back_drive, applied_heading,
                  input ready);
  modport sink (input valid, left_drive, right_drive, back_drive, applied_heading,
                output ready);
endinterface

interface omd_cfg_if import omd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

>>> src/omd_lane.sv
// One wheel lane: bit-serial multiply of gain by power, then a restoring
// divide by twice the largest gain, one quotient bit per cycle. Uses omd_pkg.
module omd_lane import omd_pkg::*; #(
  parameter int GainW = COS_FRAC_BITS_DEF + 1
) (
  input  logic                     clk_i,
  input  lane_ctrl_t               ctrl_i,
  input  logic [GainW-1:0]         mag_i,
  input  logic [GainW-1:0]         max_i,
  input  logic                     neg_i,
  input  logic [PWR_W-1:0]         power_i,
  input  logic signed [SPIN_W-1:0] spin_i,
  output logic signed [DRV_W-1:0]  drive_o
);

  localparam int AccW = GainW + PWR_W;
  localparam int NumW = AccW + 2;

  logic [AccW-1:0]  acc_q;
  logic [PWR_W-1:0] mplier_q;
  logic [NumW-1:0]  rem_q;
  logic [NumW-1:0]  dsr_q;
  logic [PWR_W-1:0] quo_q;
  logic             zero_q;

  logic [PWR_W-1:0]        q_eff;
  logic signed [DRV_W-1:0] q_s;
  logic signed [DRV_W-1:0] spin_s;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q    <= '0;
      mplier_q <= power_i;
    end else if (ctrl_i.mul_en) begin
      // Most significant power bit first: shift the sum, then add the gain.
      acc_q    <= {acc_q[AccW-2:0], 1'b0} +
                  (mplier_q[PWR_W-1] ? AccW'(mag_i) : '0);
      mplier_q <= {mplier_q[PWR_W-2:0], 1'b0};
    end
    if (ctrl_i.div_load) begin
      // Numerator 2*|g|*p + m, divisor 2*m aligned to the top quotient bit.
      rem_q  <= {1'b0, acc_q, 1'b0} + NumW'(max_i);
      dsr_q  <= NumW'({max_i, {PWR_W{1'b0}}});
      quo_q  <= '0;
      zero_q <= (max_i == '0);
    end else if (ctrl_i.div_en) begin
      if (rem_q >= dsr_q) begin
        rem_q <= rem_q - dsr_q;
        quo_q <= {quo_q[PWR_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[PWR_W-2:0], 1'b0};
      end
      dsr_q <= dsr_q >> 1;
    end
  end

  // With all gains zero only the spin term remains.
  assign q_eff   = zero_q ? '0 : quo_q;
  assign q_s     = signed'(DRV_W'(q_eff));
  assign spin_s  = DRV_W'(spin_i);
  assign drive_o = (neg_i ? -q_s : q_s) + spin_s;

endmodule

>>> src/three_wheel_omni_drive_mixer.sv
// Three-wheel omni drive mixer, top level. Instantiates three omd_lane
// units and the sequencer; uses omd_pkg and the channels in omd_channels.
//
// Usage: input items arrive on in_i (heading, drive_power, line_zone, spin),
// results leave on out_o (three drives and the applied heading), and the
// four registers are written through cfg_i, which is always ready. Write the
// registers only while the block is idle.
// An item whose corrected heading, effective power and spin equal those of
// the last emitting item is absorbed in its accept cycle with no result.
// Any other item runs through angle fold, table lookup, a bit-serial multiply
// and a restoring divide in each lane; its result is registered into the
// output register from the done step. Both serial loops run over the 8-bit
// power width.
// in_i.ready is high only while the sequencer is idle.
// A stalled receiver holds the result in the output register; the next item
// may still be accepted and worked, and waits in its last step until the
// register frees. Reset restores the register defaults and clears the
// last-emitted values, so the first item after reset always emits.
module three_wheel_omni_drive_mixer import omd_pkg::*; #(
  parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  omd_in_if.sink     in_i,
  omd_out_if.source  out_o,
  omd_cfg_if.sink    cfg_i
);

  localparam int GainW = COS_FRAC_BITS + 1;
  localparam cos_tab_t CosTab = cos_table(COS_FRAC_BITS);

  omd_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [PWR_W-1:0] on_line_power_q;
  logic [ANG_W-1:0] angle_q [NUM_WHEELS];

  logic [HDG_W-1:0]         dir_q;
  logic [PWR_W-1:0]         pwr_q;
  logic signed [SPIN_W-1:0] spin_q;
  logic                     have_prev_q;

  cos_fold_t        fold_q [NUM_WHEELS];
  logic [GainW-1:0] mag_q [NUM_WHEELS];
  logic [GainW-1:0] max01;
  logic [GainW-1:0] max_all;
  logic signed [DRV_W-1:0] drive [NUM_WHEELS];

  logic                    out_valid_q;
  logic signed [DRV_W-1:0] left_q, right_q, back_q;
  logic [HDG_W-1:0]        hdg_out_q;

  logic [HDG_W-1:0] hdg_mod;
  logic [HDG_W-1:0] dir_n;
  logic [PWR_W-1:0] pwr_n;
  logic             in_acc;
  logic             changed;
  logic             start;
  logic             in_ready;
  logic             out_load;
  lane_ctrl_t       ctrl;

  // Configuration writes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_line_power_q      <= ON_LINE_POWER_RST;
      angle_q[WHEEL_LEFT]  <= LEFT_ANGLE_RST;
      angle_q[WHEEL_RIGHT] <= RIGHT_ANGLE_RST;
      angle_q[WHEEL_BACK]  <= BACK_ANGLE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        CFG_ON_LINE_POWER: on_line_power_q      <= cfg_i.data[PWR_W-1:0];
        CFG_LEFT_ANGLE:    angle_q[WHEEL_LEFT]  <= cfg_i.data[ANG_W-1:0];
        CFG_RIGHT_ANGLE:   angle_q[WHEEL_RIGHT] <= cfg_i.data[ANG_W-1:0];
        CFG_BACK_ANGLE:    angle_q[WHEEL_BACK]  <= cfg_i.data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: heading reduction, line correction and the repeat filter.
  assign hdg_mod = (in_i.heading >= 9'd360) ? in_i.heading - 9'd360 : in_i.heading;
  assign dir_n   = correct_heading(hdg_mod, in_i.line_zone);
  assign pwr_n   = (in_i.line_zone != ZONE_FIELD) ? on_line_power_q : in_i.drive_power;
  assign in_acc  = in_i.valid && in_ready;
  assign changed = !have_prev_q || (dir_n != dir_q) || (pwr_n != pwr_q) ||
                   (in_i.spin != spin_q);
  assign start   = in_acc && changed;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= '0;
      pwr_q       <= '0;
      spin_q      <= '0;
      have_prev_q <= 1'b0;
    end else if (start) begin
      dir_q       <= dir_n;
      pwr_q       <= pwr_n;
      spin_q      <= in_i.spin;
      have_prev_q <= 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (start) state_d = ST_ANGLE;
      ST_ANGLE:    state_d = ST_LOOKUP;
      ST_LOOKUP:   state_d = ST_MULT;
      ST_MULT:     if (step_q == STEP_LAST) state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIVIDE;
      ST_DIVIDE:   if (step_q == STEP_LAST) state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl          = '0;
    out_load      = 1'b0;
    step_d        = '0;
    case (state_q)
      ST_IDLE:     in_ready = 1'b1;
      ST_ANGLE:    ;
      ST_LOOKUP:   ctrl.load = 1'b1;
      ST_MULT: begin
        ctrl.mul_en = 1'b1;
        step_d      = step_q + 1'b1;
      end
      ST_DIV_LOAD: ctrl.div_load = 1'b1;
      ST_DIVIDE: begin
        ctrl.div_en = 1'b1;
        step_d      = step_q + 1'b1;
      end
      ST_DONE:     out_load = !out_valid_q || out_o.ready;
      default:     ;
    endcase
  end

  // Angle fold and cosine lookup, one stage each.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (state_q == ST_ANGLE) begin
        fold_q[i] <= cos_fold(SUM_W'(angle_q[i]) + SUM_W'(dir_q) + 10'd90);
      end
      if (state_q == ST_LOOKUP) begin
        mag_q[i] <= CosTab[fold_q[i].k][GainW-1:0];
      end
    end
  end

  assign max01   = (mag_q[WHEEL_RIGHT] > mag_q[WHEEL_LEFT]) ?
                   mag_q[WHEEL_RIGHT] : mag_q[WHEEL_LEFT];
  assign max_all = (mag_q[WHEEL_BACK] > max01) ? mag_q[WHEEL_BACK] : max01;

  for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
    omd_lane #(
      .GainW (GainW)
    ) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .mag_i   (mag_q[g]),
      .max_i   (max_all),
      .neg_i   (fold_q[g].neg),
      .power_i (pwr_q),
      .spin_i  (spin_q),
      .drive_o (drive[g])
    );
  end

  // Output register keeps the result while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q    <= drive[WHEEL_LEFT];
      right_q   <= drive[WHEEL_RIGHT];
      back_q    <= drive[WHEEL_BACK];
      hdg_out_q <= dir_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.left_drive      = left_q;
  assign out_o.right_drive     = right_q;
  assign out_o.back_drive      = back_q;
  assign out_o.applied_heading = hdg_out_q;

endmodule
